// ----- rtl/svc_pkg.sv -----
// Shared constants, result type and a helper function for the signed varint codec.
package svc_pkg;

   // Value width and the longest run of groups.
   localparam int VALUE_BITS = 64;
   localparam int MAX_GROUPS = 10;
   localparam int GROUP_BITS = 7;
   localparam int DATA_BITS  = 64;
   localparam int IDX_BITS   = $clog2(MAX_GROUPS + 1);

   // Operation codes carried in req_tuser.
   localparam logic FUNC_ENCODE = 1'b0;
   localparam logic FUNC_DECODE = 1'b1;

   // One result beat.
   typedef struct packed {
      logic [7:0]           byte_out;
      logic [DATA_BITS-1:0] value_out;
      logic                 is_value;
      logic                 last;
      logic                 overflow;
   } rsp_type;

   // Keep the low VALUE_BITS bits and sign-extend from the top one.
   function automatic logic [DATA_BITS-1:0] sext_value(input logic [DATA_BITS-1:0] x);
      logic [DATA_BITS-1:0] m;
      logic [DATA_BITS-1:0] r;
      m = {DATA_BITS{1'b1}} >> (DATA_BITS - VALUE_BITS);
      r = x & m;
      if (r[VALUE_BITS-1]) begin
         r = r | ~m;
      end
      return r;
   endfunction

endpackage

// ----- rtl/signed_varint_codec.sv -----
// Top level of the signed varint codec: request intake, encoder, decoder, result register.
//
//  channel | direction | tdata (low bit up)                 | tuser (low bit up)   | tlast
//  req_    | in        | value_in[63:0], byte_in[71:64]     | func                 | -
//  rsp_    | out       | byte_out[7:0], value_out[71:8]     | is_value, overflow   | last
//
// Decode takes one byte per cycle when the result slot is free and the encoder
// idle; a final byte's value is in the result register the cycle after it is
// accepted. Encode emits one byte per cycle when the result slot is free, from a
// 64-bit register shifted 7 bits at a time; req_tready is low while a value still
// has bytes to emit. Reset (synchronous) clears decode state, the encoder's busy
// flag and the result valid flag. A stalled result beat holds, and stops both sides.
module signed_varint_codec (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,  // value_in[63:0], byte_in[71:64]
   input  logic [0:0]  req_tuser,  // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,  // byte_out[7:0], value_out[71:8]
   output logic [1:0]  rsp_tuser,  // is_value, overflow
   output logic        rsp_tlast
);

   logic             rsp_valid_ff, rsp_valid_in;
   svc_pkg::rsp_type rsp_ff, rsp_in;

   logic             slot_free;
   logic             accept;
   logic             enc_busy;
   logic             enc_emit;
   logic             dec_emit;
   svc_pkg::rsp_type enc_rsp;
   svc_pkg::rsp_type dec_rsp;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = !enc_busy && slot_free;
   assign accept     = req_tvalid && req_tready;

   svc_encoder u_enc (
      .clock    (clock),
      .reset    (reset),
      .start    (accept && (req_tuser[0] == svc_pkg::FUNC_ENCODE)),
      .value_in (req_tdata[63:0]),
      .advance  (slot_free),
      .busy     (enc_busy),
      .emit     (enc_emit),
      .rsp      (enc_rsp)
   );

   svc_decoder u_dec (
      .clock   (clock),
      .reset   (reset),
      .take    (accept && (req_tuser[0] == svc_pkg::FUNC_DECODE)),
      .byte_in (req_tdata[71:64]),
      .emit    (dec_emit),
      .rsp     (dec_rsp)
   );

   // Result register: loads a beat from whichever unit emits.
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (enc_emit) begin
         rsp_in       = enc_rsp;
         rsp_valid_in = 1'b1;
      end else if (dec_emit) begin
         rsp_in       = dec_rsp;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.value_out, rsp_ff.byte_out};
   assign rsp_tuser  = {rsp_ff.overflow, rsp_ff.is_value};
   assign rsp_tlast  = rsp_ff.last;

endmodule

// ----- rtl/svc_encoder.sv -----
// Encoder: 64-bit shift register that drops one 7-bit group per emitted byte.
module svc_encoder (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [svc_pkg::DATA_BITS-1:0] value_in,
   input  logic                          advance,
   output logic                          busy,
   output logic                          emit,
   output svc_pkg::rsp_type              rsp
);

   logic [svc_pkg::DATA_BITS-1:0] x_ff, x_in;
   logic [svc_pkg::IDX_BITS-1:0]  k_ff, k_in;
   logic                          busy_ff, busy_in;

   logic [svc_pkg::DATA_BITS-1:0] src;
   logic [svc_pkg::IDX_BITS-1:0]  k_cur;
   logic                          in_range;
   logic                          final_byte;

   // Current remainder: fresh value on start, else the shifted one.
   assign src      = busy_ff ? x_ff : svc_pkg::sext_value(value_in);
   assign k_cur    = busy_ff ? k_ff : '0;
   assign in_range = (&src[svc_pkg::DATA_BITS-1:6]) | ~(|src[svc_pkg::DATA_BITS-1:6]);
   assign final_byte = in_range ||
                       (k_cur == svc_pkg::IDX_BITS'(svc_pkg::MAX_GROUPS - 1));
   assign emit     = start || (busy_ff && advance);
   assign busy     = busy_ff;

   // Byte beat.
   always_comb begin
      rsp           = '0;
      rsp.byte_out  = {~final_byte, src[6:0]};
      rsp.last      = final_byte;
   end

   // Shift by one group per emitted byte.
   always_comb begin
      x_in    = x_ff;
      k_in    = k_ff;
      busy_in = busy_ff;
      if (emit) begin
         if (final_byte) begin
            busy_in = 1'b0;
         end else begin
            busy_in = 1'b1;
            x_in    = {{svc_pkg::GROUP_BITS{src[svc_pkg::DATA_BITS-1]}},
                       src[svc_pkg::DATA_BITS-1:svc_pkg::GROUP_BITS]};
            k_in    = k_cur + svc_pkg::IDX_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         k_ff    <= '0;
      end else begin
         busy_ff <= busy_in;
         k_ff    <= k_in;
      end
      x_ff <= x_in;
   end

endmodule

// ----- rtl/svc_decoder.sv -----
// Decoder: accumulates one 7-bit group per byte, up to MAX_GROUPS groups, and emits on the final byte.
module svc_decoder (
   input  logic             clock,
   input  logic             reset,
   input  logic             take,
   input  logic [7:0]       byte_in,
   output logic             emit,
   output svc_pkg::rsp_type rsp
);

   logic [svc_pkg::DATA_BITS-1:0] acc_ff, acc_in;
   logic [svc_pkg::IDX_BITS-1:0]  idx_ff, idx_in;
   logic                          ovf_ff, ovf_in;

   logic                          beyond;
   logic                          final_byte;
   logic [svc_pkg::DATA_BITS-1:0] group;
   logic [svc_pkg::DATA_BITS-1:0] placed;
   logic [svc_pkg::DATA_BITS-1:0] sum;

   assign beyond     = (idx_ff == svc_pkg::IDX_BITS'(svc_pkg::MAX_GROUPS));
   assign final_byte = ~byte_in[7];
   assign emit       = take && final_byte;

   // Group, sign-extended only on the final byte.
   assign group = {{(svc_pkg::DATA_BITS - 7){final_byte & byte_in[6]}}, byte_in[6:0]};

   // Place the group at its slot; lower bits of acc are the only ones set.
   always_comb begin
      placed = '0;
      for (int g = 0; g < svc_pkg::MAX_GROUPS; g++) begin
         if (idx_ff == svc_pkg::IDX_BITS'(g)) begin
            placed = group << (svc_pkg::GROUP_BITS * g);
         end
      end
   end

   assign sum = beyond ? acc_ff : (acc_ff | placed);

   // Value beat.
   always_comb begin
      rsp           = '0;
      rsp.value_out = svc_pkg::sext_value(sum);
      rsp.is_value  = 1'b1;
      rsp.overflow  = ovf_ff | beyond;
   end

   // Decode state update.
   always_comb begin
      acc_in = acc_ff;
      idx_in = idx_ff;
      ovf_in = ovf_ff;
      if (take) begin
         if (final_byte) begin
            acc_in = '0;
            idx_in = '0;
            ovf_in = 1'b0;
         end else if (beyond) begin
            ovf_in = 1'b1;
         end else begin
            acc_in = sum;
            idx_in = idx_ff + svc_pkg::IDX_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         idx_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         acc_ff <= acc_in;
         idx_ff <= idx_in;
         ovf_ff <= ovf_in;
      end
   end

endmodule
